>>> hdl/tlb_page_table_translator_defines.svh
// assertion macros for the tlb page table translator
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TLBPT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TLBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLBPT_ASSERT(label, expr, msg)
`define TLBPT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/tlbpt_pkg.sv
`timescale 1ns / 1ps
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BITS   = 8;
  localparam int OFFSET_BITS = 8;
  localparam int ADDR_W      = 16;
  localparam int COUNT_W     = 16;

  localparam int PAGE_COUNT  = 1 << PAGE_BITS;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int FILL_W      = $clog2(TLB_ENTRIES + 1);

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COUNT_W-1:0]     count_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

>>> hdl/tlbpt_intf.sv
`timescale 1ns / 1ps
interface tlbpt_in_if
  import tlbpt_pkg::*;
;
  logic  valid;
  logic  ready;
  addr_t virt_addr;

  modport source (output valid, output virt_addr, input ready);
  modport sink (input valid, input virt_addr, output ready);
endinterface

interface tlbpt_out_if
  import tlbpt_pkg::*;
;
  logic   valid;
  logic   ready;
  addr_t  physical_address;
  logic   tlb_hit;
  logic   page_fault;
  count_t hit_total;
  count_t fault_total;

  modport source (
    output valid, output physical_address, output tlb_hit, output page_fault,
    output hit_total, output fault_total, input ready
  );
  modport sink (
    input valid, input physical_address, input tlb_hit, input page_fault,
    input hit_total, input fault_total, output ready
  );
endinterface

>>> hdl/tlbpt_ctrl.sv
`timescale 1ns / 1ps
`include "tlb_page_table_translator_defines.svh"
module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    cmd.capture = in_valid && in_ready;
    cmd.commit  = (state_r == S_LOOKUP) && (!out_valid_r || out_ready);

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TLBPT_ASSERT(a_no_overlap, !(cmd.capture && cmd.commit), "capture and commit together")
  `TLBPT_ASSERT_NEXT(a_capture_lookup, cmd.capture, state_r == S_LOOKUP, "capture without lookup")
  `TLBPT_ASSERT_NEXT(a_commit_result, cmd.commit, out_valid_r && state_r == S_IDLE, "commit lost result")
  `TLBPT_ASSERT(a_lookup_no_accept, !(state_r == S_LOOKUP && in_ready), "accept during lookup")

endmodule

>>> hdl/tlbpt_dp.sv
`timescale 1ns / 1ps
module tlbpt_dp
  import tlbpt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  addr_t  virt_addr,
  output addr_t  physical_address,
  output logic   tlb_hit,
  output logic   page_fault,
  output count_t hit_total,
  output count_t fault_total
);

  page_t   page_r;
  offset_t offset_r;
  page_t   map_rd_r;

  page_t   tag_r [TLB_ENTRIES];
  page_t   frm_r [TLB_ENTRIES];
  page_t   tag_nxt [TLB_ENTRIES];
  page_t   frm_nxt [TLB_ENTRIES];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [PAGE_COUNT-1:0] map_valid_r;
  logic [PAGE_BITS:0]   next_free_r;
  count_t  hit_cnt_r, fault_cnt_r;

  page_t   map_frame [PAGE_COUNT];

  addr_t   pa_r;
  logic    hit_r, fault_r;
  count_t  hit_tot_r, fault_tot_r;

  logic [TLB_ENTRIES-1:0] match;
  logic [TLB_IDX_W-1:0]   pos;
  logic                   hit, fault, full, do_shift;
  page_t                  frame;
  logic [FILL_W-1:0]      shift_from, new_idx;
  count_t                 hit_cnt_nxt, fault_cnt_nxt;

  always_comb begin
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      match[k] = (FILL_W'(k) < fill_r) && (tag_r[k] == page_r);
    end
    pos = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        pos = TLB_IDX_W'(k);
      end
    end
    hit   = |match;
    fault = !hit && !map_valid_r[page_r];
    if (hit) begin
      frame = frm_r[pos];
    end else if (!fault) begin
      frame = map_rd_r;
    end else begin
      frame = next_free_r[PAGE_BITS-1:0];
    end
    full       = (fill_r == FILL_W'(TLB_ENTRIES));
    do_shift   = hit || full;
    shift_from = hit ? FILL_W'(pos) : '0;
    new_idx    = do_shift ? fill_r - 1'b1 : fill_r;
    fill_nxt   = do_shift ? fill_r : fill_r + 1'b1;

    hit_cnt_nxt   = hit_cnt_r;
    fault_cnt_nxt = fault_cnt_r;
    if (hit && hit_cnt_r != '1) begin
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end
    if (fault && fault_cnt_r != '1) begin
      fault_cnt_nxt = fault_cnt_r + 1'b1;
    end
  end

  // per-entry queue update: close the gap, new entry at the recent end
  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_entry
    page_t tag_up, frm_up;
    if (g < TLB_ENTRIES - 1) begin : g_up
      assign tag_up = tag_r[g+1];
      assign frm_up = frm_r[g+1];
    end else begin : g_top
      assign tag_up = tag_r[g];
      assign frm_up = frm_r[g];
    end
    always_comb begin
      tag_nxt[g] = tag_r[g];
      frm_nxt[g] = frm_r[g];
      if (FILL_W'(g) == new_idx) begin
        tag_nxt[g] = page_r;
        frm_nxt[g] = frame;
      end else if (do_shift && FILL_W'(g) >= shift_from && FILL_W'(g) < new_idx) begin
        tag_nxt[g] = tag_up;
        frm_nxt[g] = frm_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      map_valid_r <= '0;
      next_free_r <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
    end else if (cmd.commit) begin
      fill_r      <= fill_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      if (fault) begin
        map_valid_r[page_r] <= 1'b1;
        next_free_r         <= next_free_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r   <= PAGE_BITS'(virt_addr >> OFFSET_BITS);
      offset_r <= virt_addr[OFFSET_BITS-1:0];
    end
    if (cmd.commit) begin
      tag_r       <= tag_nxt;
      frm_r       <= frm_nxt;
      pa_r        <= ADDR_W'({frame, offset_r});
      hit_r       <= hit;
      fault_r     <= fault;
      hit_tot_r   <= hit_cnt_nxt;
      fault_tot_r <= fault_cnt_nxt;
    end
  end

  // page map frame store
  always_ff @(posedge clk) begin
    if (cmd.commit && fault) begin
      map_frame[page_r] <= frame;
    end
    if (cmd.capture) begin
      map_rd_r <= map_frame[PAGE_BITS'(virt_addr >> OFFSET_BITS)];
    end
  end

  assign physical_address = pa_r;
  assign tlb_hit          = hit_r;
  assign page_fault       = fault_r;
  assign hit_total        = hit_tot_r;
  assign fault_total      = fault_tot_r;

endmodule

>>> hdl/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// result valid once the lookup commits; the commit waits while an older result is untaken
// no new input until the page map read and then the tlb and map update of the last are done
// the next input is taken while a finished result still waits in the output register
// reset (synchronous, active low) clears the tlb fill count, page map valid bits,
// the free frame counter and the hit and fault counts at once; no clearing pass
module tlb_page_table_translator
  import tlbpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tlbpt_in_if.sink    in_ch,
  tlbpt_out_if.source out_ch
);

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  tlbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tlbpt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .virt_addr        (in_ch.virt_addr),
    .physical_address (out_ch.physical_address),
    .tlb_hit          (out_ch.tlb_hit),
    .page_fault       (out_ch.page_fault),
    .hit_total        (out_ch.hit_total),
    .fault_total      (out_ch.fault_total)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
